### src/wsmc_pkg.sv
package wsmc_pkg;

    // number of chained matrix units
    localparam int UNITS = 4;
    localparam int UIDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam logic [UIDX_W-1:0] LAST_UNIT = UIDX_W'(UNITS - 1);

    localparam int ROWS = 8;
    localparam logic [2:0] LAST_ROW = 3'(ROWS - 1);

    // input item kinds
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // configuration register indexes
    localparam logic CFG_WALK_SECONDS    = 1'b0;
    localparam logic CFG_COUNTDOWN_START = 1'b1;

    localparam logic [7:0] WALK_SECONDS_RST    = 8'd5;
    localparam logic [3:0] COUNTDOWN_START_RST = 4'd9;
    localparam logic [3:0] MAX_DIGIT           = 4'd9;

    localparam logic [3:0] GLYPH_HAND   = 4'd10;
    localparam logic [3:0] GLYPH_WALKER = 4'd11;

    typedef enum logic [1:0] {
        PH_HAND  = 2'd0,
        PH_WALK  = 2'd1,
        PH_COUNT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_EMIT
    } t_state;

    // row r of a glyph sits in bits [8r+7:8r]
    localparam logic [63:0] FONT [12] = '{
        64'h003C6666766E663C,
        64'h003C181818183818,
        64'h007E30180C06663C,
        64'h003C66061C06663C,
        64'h000C0C7E4C2C1C0C,
        64'h003C6606067C607E,
        64'h003C66667C60663C,
        64'h00303030180C067E,
        64'h003C66663C66663C,
        64'h003C66063E66663C,
        64'h18003C3C3C3C3C3C,
        64'h004224187E183C18
    };

    function automatic logic [7:0] font_row(input logic [3:0] glyph, input logic [2:0] row);
        logic [63:0] bits;
        bits = FONT[glyph];
        return bits[{row, 3'b000} +: 8];
    endfunction

endpackage

### src/walk_signal_matrix_controller_core.sv
// channel   | direction | fields (low bit first)                          | handshake
// ----------+-----------+-------------------------------------------------+----------------------
// s_axis    | in        | tdata: unit[1:0]; tuser: cmd                    | tvalid && tready
// m_axis    | out       | tdata: row_address, unit_index, row_bits,       | tvalid && tready
//           |           |        latch_after; tlast: last                 |
// cfg       | in        | index (0 walk_seconds, 1 countdown_start), data | i_cfg_valid && o_cfg_ready
//
// a start request is taken from idle and produces nothing
// a tick steps the units one at a time through the shared step unit, then emits 8*UNITS
// packets, one per cycle while the output is not stalled
// output stalls pause emission; the final packet may still wait while the next item is taken
// synchronous active-low reset puts every unit in hand phase and restores register defaults
module walk_signal_matrix_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] unit, rest zero
    input  logic        s_axis_tuser,   // [0] cmd
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] row_address, [5:4] unit_index,
                                        // [13:6] row_bits, [14] latch_after, [15] zero
    output logic        m_axis_tlast,   // last
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int UW = wsmc_pkg::UIDX_W;

    // sequencer
    wsmc_pkg::t_state r_state, n_state;
    logic [UW-1:0]    r_idx, n_idx;
    logic [2:0]       r_row, n_row;

    // per-unit state
    wsmc_pkg::t_phase r_phase [wsmc_pkg::UNITS];
    wsmc_pkg::t_phase n_phase [wsmc_pkg::UNITS];
    logic [7:0]       r_walk  [wsmc_pkg::UNITS];
    logic [7:0]       n_walk  [wsmc_pkg::UNITS];
    logic [3:0]       r_digit [wsmc_pkg::UNITS];
    logic [3:0]       n_digit [wsmc_pkg::UNITS];

    // configuration
    logic [7:0] r_walk_seconds;
    logic [3:0] r_cd_start;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [3:0] r_out_addr,  n_out_addr;
    logic [1:0] r_out_unit,  n_out_unit;
    logic [7:0] r_out_bits,  n_out_bits;
    logic       r_out_latch, n_out_latch;
    logic       r_out_last,  n_out_last;

    // shared step unit, fed by the unit at r_idx
    wsmc_pkg::t_phase cur_phase;
    logic [7:0]       cur_walk;
    logic [3:0]       cur_digit;
    wsmc_pkg::t_phase step_phase;
    logic [7:0]       step_walk;
    logic [3:0]       step_digit;
    logic [3:0]       load_digit;
    logic [3:0]       glyph;
    logic             out_free;

    assign cur_phase  = r_phase[r_idx];
    assign cur_walk   = r_walk[r_idx];
    assign cur_digit  = r_digit[r_idx];
    assign load_digit = (r_cd_start > wsmc_pkg::MAX_DIGIT) ? wsmc_pkg::MAX_DIGIT : r_cd_start;

    always_comb begin
        step_phase = cur_phase;
        step_walk  = cur_walk;
        step_digit = cur_digit;
        unique case (cur_phase)
            wsmc_pkg::PH_WALK: begin
                if (cur_walk != 8'd0) begin
                    step_walk = cur_walk - 8'd1;
                end
                // walk time used up: start the countdown
                if (step_walk == 8'd0) begin
                    step_phase = wsmc_pkg::PH_COUNT;
                    step_digit = load_digit;
                end
            end
            wsmc_pkg::PH_COUNT: begin
                if (cur_digit != 4'd0) begin
                    step_digit = cur_digit - 4'd1;
                end else begin
                    step_phase = wsmc_pkg::PH_HAND;
                end
            end
            default: begin
                // hand phase holds
            end
        endcase
    end

    // glyph shown by the unit at r_idx
    always_comb begin
        unique case (cur_phase)
            wsmc_pkg::PH_WALK:  glyph = wsmc_pkg::GLYPH_WALKER;
            wsmc_pkg::PH_COUNT: glyph = (cur_digit > wsmc_pkg::MAX_DIGIT) ?
                                        wsmc_pkg::MAX_DIGIT : cur_digit;
            default:            glyph = wsmc_pkg::GLYPH_HAND;
        endcase
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == wsmc_pkg::S_IDLE);

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_row       = r_row;
        n_phase     = r_phase;
        n_walk      = r_walk;
        n_digit     = r_digit;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_addr  = r_out_addr;
        n_out_unit  = r_out_unit;
        n_out_bits  = r_out_bits;
        n_out_latch = r_out_latch;
        n_out_last  = r_out_last;

        unique case (r_state)
            wsmc_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == wsmc_pkg::CMD_START) begin
                        // start only takes effect from hand phase
                        for (int u = 0; u < wsmc_pkg::UNITS; u++) begin
                            if (int'(s_axis_tdata[1:0]) == u &&
                                r_phase[u] == wsmc_pkg::PH_HAND) begin
                                n_phase[u] = wsmc_pkg::PH_WALK;
                                n_walk[u]  = r_walk_seconds;
                            end
                        end
                    end else begin
                        n_state = wsmc_pkg::S_STEP;
                        n_idx   = '0;
                    end
                end
            end
            wsmc_pkg::S_STEP: begin
                n_phase[r_idx] = step_phase;
                n_walk[r_idx]  = step_walk;
                n_digit[r_idx] = step_digit;
                if (r_idx == wsmc_pkg::LAST_UNIT) begin
                    // emission starts at the last unit, row 0
                    n_state = wsmc_pkg::S_EMIT;
                    n_row   = 3'd0;
                end else begin
                    n_idx = r_idx + UW'(1);
                end
            end
            wsmc_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = 4'(r_row) + 4'd1;
                    n_out_unit  = 2'(r_idx);
                    n_out_bits  = wsmc_pkg::font_row(glyph, r_row);
                    n_out_latch = (r_idx == '0);
                    n_out_last  = (r_idx == '0) && (r_row == wsmc_pkg::LAST_ROW);
                    if (r_idx == '0) begin
                        n_idx = wsmc_pkg::LAST_UNIT;
                        n_row = r_row + 3'd1;
                        if (r_row == wsmc_pkg::LAST_ROW) begin
                            n_state = wsmc_pkg::S_IDLE;
                        end
                    end else begin
                        n_idx = r_idx - UW'(1);
                    end
                end
            end
            default: begin
                n_state = wsmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsmc_pkg::S_IDLE;
            r_idx       <= '0;
            r_row       <= 3'd0;
            r_out_valid <= 1'b0;
            for (int u = 0; u < wsmc_pkg::UNITS; u++) begin
                r_phase[u] <= wsmc_pkg::PH_HAND;
                r_walk[u]  <= 8'd0;
                r_digit[u] <= 4'd0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_walk      <= n_walk;
            r_digit     <= n_digit;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out_addr  <= n_out_addr;
        r_out_unit  <= n_out_unit;
        r_out_bits  <= n_out_bits;
        r_out_latch <= n_out_latch;
        r_out_last  <= n_out_last;
    end

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_seconds <= wsmc_pkg::WALK_SECONDS_RST;
            r_cd_start     <= wsmc_pkg::COUNTDOWN_START_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wsmc_pkg::CFG_WALK_SECONDS:    r_walk_seconds <= i_cfg_data;
                wsmc_pkg::CFG_COUNTDOWN_START: r_cd_start     <= i_cfg_data[3:0];
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_latch, r_out_bits, r_out_unit, r_out_addr};
    assign m_axis_tlast  = r_out_last;

endmodule

### src/wsmc_checker.sv
module wsmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a tick keeps the input closed while it works
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == wsmc_pkg::CMD_TICK
        |=> !s_axis_tready)
        else $error("input ready right after a tick");

    // final packet closes row 8 and latches
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast
        |-> m_axis_tdata[3:0] == 4'd8 && m_axis_tdata[14] && m_axis_tdata[5:4] == 2'd0)
        else $error("last packet not on row 8 unit 0");

    // row address stays within 1..8
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] != 4'd0 && !(m_axis_tdata[3] && (|m_axis_tdata[2:0])))
        else $error("row address out of range");

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed under stall");

endmodule

bind walk_signal_matrix_controller_core wsmc_checker u_wsmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
